>>> src/trc_pkg.sv
// Shared types, codes and functions of the transaction run coalescer.
`timescale 1ns / 1ps

package trc_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int MAX_VALUES_DEF = 6;
  localparam int VAL_W          = 35;   // size in bits 34..32, bytes below
  localparam int IN_DATA_W      = 160;
  localparam int OUT_DATA_W     = 240;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_VAL = 2'd1;
  localparam logic [1:0] KIND_NEW = 2'd2;

  localparam logic [2:0] ST_WR_OK   = 3'd3;
  localparam logic [2:0] ST_WR_FAIL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_PROC, S_EMIT, S_WHDR, S_WVAL, S_OPEN
  } state_t;

  typedef enum logic [1:0] {
    AFT_NONE, AFT_WRITE, AFT_OPEN
  } after_t;

  // One decoded transaction record as the cells see it.
  typedef struct packed {
    logic [39:0]      target;
    logic [33:0]      key;
    logic             err;
    logic [15:0]      wkc;
    logic [31:0]      ms;
    logic [VAL_W-1:0] val;
    logic             st_ok;
  } rec_t;

  // Fixed part of one run held by a cell.
  typedef struct packed {
    logic [39:0]      target;
    logic [33:0]      key;
    logic             err;
    logic [31:0]      count;
    logic [31:0]      work;
    logic [63:0]      time_b;
    logic             ovf;
    logic [VAL_W-1:0] newest;
  } slot_hdr_t;

  function automatic logic [OUT_DATA_W-1:0] pack_out(
    input logic [2:0]       status,
    input logic [39:0]      target,
    input logic [31:0]      abort_key,
    input logic [31:0]      count,
    input logic [31:0]      work,
    input logic [63:0]      time_b,
    input logic             err,
    input logic [VAL_W-1:0] val
  );
    return {1'b0, val[31:0], val[34:32], err, time_b, work, count, abort_key,
            target[23:0], target[39:24], status};
  endfunction

endpackage

>>> src/trc_cell.sv
// One run slot of the coalescer chain: match, update, open and shift.
`timescale 1ns / 1ps

module trc_cell #(
  parameter int MAX_VALUES = trc_pkg::MAX_VALUES_DEF,
  parameter int VCW        = $clog2(MAX_VALUES + 1)
) (
  input  logic                                      clk,
  input  trc_pkg::rec_t                             rec,
  input  logic                                      shift,
  input  logic                                      open,
  input  logic                                      upd,
  input  trc_pkg::slot_hdr_t                        nb_hdr,
  input  logic [MAX_VALUES-1:0][trc_pkg::VAL_W-1:0] nb_vals,
  input  logic [VCW-1:0]                            nb_vcnt,
  output trc_pkg::slot_hdr_t                        hdr,
  output logic [MAX_VALUES-1:0][trc_pkg::VAL_W-1:0] vals,
  output logic [VCW-1:0]                            vcnt,
  output logic                                      key_eq
);

  localparam int VIW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

  trc_pkg::slot_hdr_t                        hdr_r, hdr_nxt;
  logic [MAX_VALUES-1:0][trc_pkg::VAL_W-1:0] vals_r, vals_nxt;
  logic [VCW-1:0]                            vcnt_r, vcnt_nxt;
  logic                                      seen;
  logic                                      has_val;

  assign key_eq  = (hdr_r.target == rec.target) && (hdr_r.key == rec.key);
  assign has_val = rec.st_ok && (rec.val != '0);

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < MAX_VALUES; i++) begin
      if ((VCW'(i) < vcnt_r) && (vals_r[i] == rec.val)) begin
        seen = 1'b1;
      end
    end
  end

  always_comb begin
    hdr_nxt  = hdr_r;
    vals_nxt = vals_r;
    vcnt_nxt = vcnt_r;
    priority if (shift) begin
      hdr_nxt  = nb_hdr;
      vals_nxt = nb_vals;
      vcnt_nxt = nb_vcnt;
    end else if (open) begin
      hdr_nxt.target = rec.target;
      hdr_nxt.key    = rec.key;
      hdr_nxt.err    = rec.err;
      hdr_nxt.count  = 32'd1;
      hdr_nxt.work   = {rec.wkc, rec.wkc};
      hdr_nxt.time_b = {rec.ms, rec.ms};
      hdr_nxt.ovf    = 1'b0;
      if (has_val) begin
        hdr_nxt.newest = rec.val;
        vals_nxt[0]    = rec.val;
        vcnt_nxt       = VCW'(1);
      end else begin
        hdr_nxt.newest = '0;
        vcnt_nxt       = '0;
      end
    end else if (upd) begin
      if (hdr_r.count != 32'hFFFF_FFFF) begin
        hdr_nxt.count = hdr_r.count + 32'd1;
      end
      if (rec.wkc < hdr_r.work[15:0])   hdr_nxt.work[15:0]    = rec.wkc;
      if (rec.wkc > hdr_r.work[31:16])  hdr_nxt.work[31:16]   = rec.wkc;
      if (rec.ms < hdr_r.time_b[31:0])  hdr_nxt.time_b[31:0]  = rec.ms;
      if (rec.ms > hdr_r.time_b[63:32]) hdr_nxt.time_b[63:32] = rec.ms;
      if (has_val) begin
        hdr_nxt.newest = rec.val;
        if (!seen) begin
          if (vcnt_r < VCW'(MAX_VALUES)) begin
            vals_nxt[vcnt_r[VIW-1:0]] = rec.val;
            vcnt_nxt = vcnt_r + VCW'(1);
          end else begin
            hdr_nxt.ovf = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    vals_r <= vals_nxt;
    vcnt_r <= vcnt_nxt;
  end

  assign hdr  = hdr_r;
  assign vals = vals_r;
  assign vcnt = vcnt_r;

endmodule

>>> src/transaction_run_coalescer.sv
// Top level of the transaction run coalescer: record decode, sequencer, cell chain.
`timescale 1ns / 1ps

// The block folds bus transaction records into runs and emits the runs as beats.
// Input channel: in_tuser carries the command (read, write, flush, nop), in_tdata the
// record fields. Result channel: out_tuser carries the beat kind (header, value,
// newest value), out_tdata the run fields, out_tlast marks the final beat that an
// input beat causes. cfg_we writes the enable bit from cfg_wdata.
// One input beat is taken at a time. A read that hits or opens a slot is registered
// first and then matched against all cells at once.
// A flush, a write and a read that misses on a full table emit one beat per cycle while the
// receiver takes them; each run is one header plus its values, and after each run
// the cell chain shifts one place toward cell zero, which drives the output.
// The output register keeps a finished beat while a new input beat is taken.
// When the receiver stalls, the sequencer holds at the current beat of the run.
// Synchronous reset empties the table and clears the enable bit and the output valid;
// no clearing pass is needed, since slot contents count only below the fill count.
// Clear enable only after issuing a flush command to drain the open runs.
module transaction_run_coalescer #(
  parameter int SLOTS      = trc_pkg::SLOTS_DEF,
  parameter int MAX_VALUES = trc_pkg::MAX_VALUES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // From bit 0: slave, obj_index, subindex, outcome, abort code, work_count,
  // error_flag, value_size, value_bytes, elapsed_ms, zero pad.
  input  logic [trc_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // From bit 0: run_status, run_slave, run_object, run_abort, run_count,
  // work_range, time_range, run_error_flag, out_value_size, out_value, zero pad.
  output logic [trc_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);

  localparam int UW  = $clog2(SLOTS + 1);
  localparam int VCW = $clog2(MAX_VALUES + 1);
  localparam int VIW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int KW  = $clog2(((MAX_VALUES > 2) ? MAX_VALUES : 2) + 1);

  trc_pkg::state_t state_r, state_nxt;
  trc_pkg::after_t after_r, after_nxt;
  logic            enable_r;
  logic [UW-1:0]   used_r, used_nxt;
  logic [KW-1:0]   k_r, k_nxt;

  logic [trc_pkg::IN_DATA_W-1:0] in_data_r;
  logic [1:0]                    in_cmd_r;

  logic                           out_valid_r;
  logic [trc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                     out_kind_r;
  logic                           out_last_r;

  // Record decode from the registered input beat.
  trc_pkg::rec_t rec;
  logic [1:0]    outcome;
  logic [1:0]    st;
  logic [2:0]    vsize;
  logic [2:0]    sz;
  logic [31:0]   vbytes;
  logic [31:0]   vmasked;

  assign outcome = in_data_r[41:40];
  assign st      = (outcome == 2'd3) ? 2'd2 : outcome;
  assign vsize   = in_data_r[93:91];
  assign sz      = (vsize > 3'd4) ? 3'd4 : vsize;
  assign vbytes  = in_data_r[125:94];

  always_comb begin
    unique case (sz)
      3'd1:    vmasked = {24'd0, vbytes[7:0]};
      3'd2:    vmasked = {16'd0, vbytes[15:0]};
      3'd3:    vmasked = {8'd0, vbytes[23:0]};
      3'd4:    vmasked = vbytes;
      default: vmasked = 32'd0;
    endcase
  end

  assign rec.target = {in_data_r[15:0], in_data_r[31:16], in_data_r[39:32]};
  assign rec.key    = {st, in_data_r[73:42]};
  assign rec.err    = in_data_r[90];
  assign rec.wkc    = in_data_r[89:74];
  assign rec.ms     = in_data_r[157:126];
  assign rec.val    = (sz == 3'd0) ? '0 : {sz, vmasked};
  assign rec.st_ok  = (st == 2'd0);

  // Cell chain. Cell zero is always the next run to emit.
  trc_pkg::slot_hdr_t                        hdr   [SLOTS];
  logic [MAX_VALUES-1:0][trc_pkg::VAL_W-1:0] vals  [SLOTS];
  logic [VCW-1:0]                            vcnt  [SLOTS];
  logic [SLOTS-1:0]                          key_eq;
  logic [SLOTS-1:0]                          match;
  logic [SLOTS-1:0]                          open_v;
  logic [SLOTS-1:0]                          upd_v;
  logic                                      shift;
  logic                                      hit;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int NB = (i < SLOTS - 1) ? i + 1 : i;
    trc_cell #(
      .MAX_VALUES(MAX_VALUES),
      .VCW       (VCW)
    ) u_cell (
      .clk    (clk),
      .rec    (rec),
      .shift  (shift),
      .open   (open_v[i]),
      .upd    (upd_v[i]),
      .nb_hdr (hdr[NB]),
      .nb_vals(vals[NB]),
      .nb_vcnt(vcnt[NB]),
      .hdr    (hdr[i]),
      .vals   (vals[i]),
      .vcnt   (vcnt[i]),
      .key_eq (key_eq[i])
    );
    assign match[i] = key_eq[i] && (UW'(i) < used_r);
  end

  assign hit = |match;

  // Beat that cell zero offers at step k of its run.
  logic [KW-1:0]             last_k;
  logic [KW-1:0]             kidx;
  logic                      run_done;
  logic [trc_pkg::VAL_W-1:0] emit_val;
  logic [1:0]                emit_kind;
  logic [2:0]                wr_status;

  assign last_k   = (vcnt[0] == '0) ? '0 : (hdr[0].ovf ? KW'(2) : KW'(vcnt[0]));
  assign kidx     = k_r - KW'(1);
  assign run_done = (k_r == last_k);
  assign wr_status = (outcome != 2'd0) ? trc_pkg::ST_WR_FAIL : trc_pkg::ST_WR_OK;

  always_comb begin
    if (k_r == '0) begin
      emit_kind = trc_pkg::KIND_HDR;
      emit_val  = '0;
    end else if (hdr[0].ovf && (k_r == KW'(2))) begin
      emit_kind = trc_pkg::KIND_NEW;
      emit_val  = hdr[0].newest;
    end else begin
      emit_kind = trc_pkg::KIND_VAL;
      emit_val  = vals[0][kidx[VIW-1:0]];
    end
  end

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == trc_pkg::S_IDLE);

  logic proc_skip;
  assign proc_skip = (in_cmd_r == trc_pkg::CMD_NOP) ||
                     (((in_cmd_r == trc_pkg::CMD_READ) || (in_cmd_r == trc_pkg::CMD_WRITE))
                      && !enable_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trc_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = trc_pkg::S_PROC;
      end
      trc_pkg::S_PROC: begin
        priority if (proc_skip) begin
          state_nxt = trc_pkg::S_IDLE;
        end else if (in_cmd_r == trc_pkg::CMD_FLUSH) begin
          state_nxt = (used_r == '0) ? trc_pkg::S_IDLE : trc_pkg::S_EMIT;
        end else if (in_cmd_r == trc_pkg::CMD_WRITE) begin
          state_nxt = (used_r == '0) ? trc_pkg::S_WHDR : trc_pkg::S_EMIT;
        end else begin
          state_nxt = (!hit && (used_r == UW'(SLOTS))) ? trc_pkg::S_EMIT : trc_pkg::S_IDLE;
        end
      end
      trc_pkg::S_EMIT: begin
        if (out_free && run_done && (used_r == UW'(1))) begin
          unique case (after_r)
            trc_pkg::AFT_WRITE: state_nxt = trc_pkg::S_WHDR;
            trc_pkg::AFT_OPEN:  state_nxt = trc_pkg::S_OPEN;
            default:            state_nxt = trc_pkg::S_IDLE;
          endcase
        end
      end
      trc_pkg::S_WHDR: begin
        if (out_free) state_nxt = (rec.val != '0) ? trc_pkg::S_WVAL : trc_pkg::S_IDLE;
      end
      trc_pkg::S_WVAL: begin
        if (out_free) state_nxt = trc_pkg::S_IDLE;
      end
      trc_pkg::S_OPEN: state_nxt = trc_pkg::S_IDLE;
      default:         state_nxt = trc_pkg::S_IDLE;
    endcase
  end

  // Datapath control and the beat to load.
  logic                           load_out;
  logic [trc_pkg::OUT_DATA_W-1:0] item_data;
  logic [1:0]                     item_kind;
  logic                           item_last;

  always_comb begin
    load_out  = 1'b0;
    item_data = '0;
    item_kind = trc_pkg::KIND_HDR;
    item_last = 1'b0;
    shift     = 1'b0;
    open_v    = '0;
    upd_v     = '0;
    used_nxt  = used_r;
    k_nxt     = k_r;
    after_nxt = after_r;
    unique case (state_r)
      trc_pkg::S_PROC: begin
        k_nxt = '0;
        if (!proc_skip) begin
          if (in_cmd_r == trc_pkg::CMD_FLUSH) begin
            after_nxt = trc_pkg::AFT_NONE;
          end else if (in_cmd_r == trc_pkg::CMD_WRITE) begin
            after_nxt = trc_pkg::AFT_WRITE;
          end else if (hit) begin
            upd_v = match;
          end else if (used_r == UW'(SLOTS)) begin
            after_nxt = trc_pkg::AFT_OPEN;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              open_v[i] = (used_r == UW'(i));
            end
            used_nxt = used_r + UW'(1);
          end
        end
      end
      trc_pkg::S_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          item_kind = emit_kind;
          item_data = trc_pkg::pack_out({1'b0, hdr[0].key[33:32]}, hdr[0].target,
                                        hdr[0].key[31:0], hdr[0].count, hdr[0].work,
                                        hdr[0].time_b, hdr[0].err, emit_val);
          item_last = run_done && (used_r == UW'(1)) && (after_r != trc_pkg::AFT_WRITE);
          if (run_done) begin
            k_nxt    = '0;
            shift    = 1'b1;
            used_nxt = used_r - UW'(1);
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      trc_pkg::S_WHDR, trc_pkg::S_WVAL: begin
        if (out_free) begin
          load_out  = 1'b1;
          item_kind = (state_r == trc_pkg::S_WHDR) ? trc_pkg::KIND_HDR : trc_pkg::KIND_VAL;
          item_data = trc_pkg::pack_out(wr_status, rec.target, rec.key[31:0], 32'd1,
                                        {rec.wkc, rec.wkc}, {rec.ms, rec.ms}, rec.err,
                                        (state_r == trc_pkg::S_WHDR) ? '0 : rec.val);
          item_last = (state_r == trc_pkg::S_WVAL) || (rec.val == '0);
        end
      end
      trc_pkg::S_OPEN: begin
        open_v[0] = 1'b1;
        used_nxt  = UW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trc_pkg::S_IDLE;
      after_r     <= trc_pkg::AFT_NONE;
      enable_r    <= 1'b0;
      used_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      used_r  <= used_nxt;
      k_r     <= k_nxt;
      if (cfg_we) enable_r <= cfg_wdata;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_cmd_r  <= in_tuser;
    end
    if (load_out) begin
      out_data_r <= item_data;
      out_kind_r <= item_kind;
      out_last_r <= item_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(SLOTS)) else $error("fill count beyond slot count");
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trc_pkg::S_PROC) |-> $onehot0(match))
    else $error("record matches more than one run");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trc_pkg::S_EMIT) |-> (used_r != '0))
    else $error("emitting from an empty table");
  a_open_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trc_pkg::S_OPEN) |-> (used_r == '0))
    else $error("opening after flush with runs left");
`endif

endmodule

>>> tb/transaction_run_coalescer_test.sv
// Self-checking testbench for the transaction run coalescer.
`timescale 1ns / 1ps

// The testbench sends transaction records and flush commands into the input
// stream. It keeps its own model of the open runs and predicts every result
// beat. A checker process compares each result beat with the oldest predicted
// beat, field by field. The sender works in bursts with random gaps. The
// receiver stalls in phases: some phases have no stalls and some stall often.
module transaction_run_coalescer_test;

  localparam int NSLOT = 8;
  localparam int NVAL  = 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;

  // One input record, packed as on in_tdata with bit 0 at the right end.
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] elapsed;
    logic [31:0] vbytes;
    logic [2:0]  vsize;
    logic        err;
    logic [15:0] wkc;
    logic [31:0] abort_val;
    logic [1:0]  outcome;
    logic [7:0]  sub;
    logic [15:0] obj;
    logic [15:0] slave;
  } record_t;

  // One result beat, packed as on out_tdata.
  typedef struct packed {
    logic        pad;
    logic [31:0] value;
    logic [2:0]  vsize;
    logic        err;
    logic [63:0] time_b;
    logic [31:0] work;
    logic [31:0] count;
    logic [31:0] abort_val;
    logic [23:0] object;
    logic [15:0] slave;
    logic [2:0]  status;
  } run_beat_t;

  typedef struct {
    logic [1:0] kind;
    run_beat_t  data;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [trc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = trc_pkg::CMD_NOP;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [trc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  transaction_run_coalescer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Model of the run table.
  bit          enabled;
  int          runs_open;
  logic [39:0] run_target [NSLOT];
  logic [33:0] run_key [NSLOT];
  logic        run_err [NSLOT];
  logic [31:0] run_cnt [NSLOT];
  logic [31:0] run_work [NSLOT];
  logic [63:0] run_time [NSLOT];
  int          run_nvals [NSLOT];
  logic        run_ovf [NSLOT];
  logic [34:0] run_vals [NSLOT][NVAL];
  logic [34:0] run_newest [NSLOT];

  result_t expected_q[$];
  result_t batch_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("Mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_beat(input logic [1:0] kind, input logic [2:0] status,
                           input logic [39:0] tgt, input logic [31:0] ab,
                           input logic [31:0] cnt, input logic [31:0] work,
                           input logic [63:0] tb, input logic err,
                           input logic [34:0] val);
    result_t r;
    r.kind = kind;
    r.last = 1'b0;
    r.data = '0;
    r.data.status = status;
    r.data.slave = tgt[39:24];
    r.data.object = tgt[23:0];
    r.data.abort_val = ab;
    r.data.count = cnt;
    r.data.work = work;
    r.data.time_b = tb;
    r.data.err = err;
    r.data.vsize = val[34:32];
    r.data.value = val[31:0];
    batch_q.push_back(r);
  endtask

  task automatic emit_run(input int s);
    logic [2:0] st;
    st = {1'b0, run_key[s][33:32]};
    push_beat(trc_pkg::KIND_HDR, st, run_target[s], run_key[s][31:0], run_cnt[s],
              run_work[s], run_time[s], run_err[s], '0);
    if (run_nvals[s] == 0) return;
    if (!run_ovf[s]) begin
      for (int k = 0; k < run_nvals[s]; k++)
        push_beat(trc_pkg::KIND_VAL, st, run_target[s], run_key[s][31:0], run_cnt[s],
                  run_work[s], run_time[s], run_err[s], run_vals[s][k]);
    end else begin
      push_beat(trc_pkg::KIND_VAL, st, run_target[s], run_key[s][31:0], run_cnt[s],
                run_work[s], run_time[s], run_err[s], run_vals[s][0]);
      push_beat(trc_pkg::KIND_NEW, st, run_target[s], run_key[s][31:0], run_cnt[s],
                run_work[s], run_time[s], run_err[s], run_newest[s]);
    end
  endtask

  task automatic flush_runs();
    for (int s = 0; s < runs_open; s++) emit_run(s);
    runs_open = 0;
  endtask

  // Works out the result beats of one accepted input beat.
  task automatic predict_runs(input logic [1:0] cmd, input record_t rec);
    logic [39:0] tgt;
    logic [34:0] val;
    logic [2:0]  sz;
    logic [1:0]  st;
    logic [33:0] key;
    logic [2:0]  wst;
    logic [15:0] lo, hi;
    logic [31:0] tlo, thi;
    int hit;
    bit seen;
    tgt = {rec.slave, rec.obj, rec.sub};
    sz = (rec.vsize > 3'd4) ? 3'd4 : rec.vsize;
    val = '0;
    if (sz != 3'd0) val = {sz, rec.vbytes & (32'hFFFF_FFFF >> (8 * (4 - sz)))};
    batch_q.delete();
    if (cmd == trc_pkg::CMD_FLUSH) begin
      flush_runs();
    end else if (cmd == trc_pkg::CMD_WRITE && enabled) begin
      flush_runs();
      wst = (rec.outcome != 2'd0) ? trc_pkg::ST_WR_FAIL : trc_pkg::ST_WR_OK;
      push_beat(trc_pkg::KIND_HDR, wst, tgt, rec.abort_val, 32'd1, {rec.wkc, rec.wkc},
                {rec.elapsed, rec.elapsed}, rec.err, '0);
      if (val != '0)
        push_beat(trc_pkg::KIND_VAL, wst, tgt, rec.abort_val, 32'd1, {rec.wkc, rec.wkc},
                  {rec.elapsed, rec.elapsed}, rec.err, val);
    end else if (cmd == trc_pkg::CMD_READ && enabled) begin
      // An outcome of 3 is folded into timeout.
      st = (rec.outcome > 2'd2) ? 2'd2 : rec.outcome;
      key = {st, rec.abort_val};
      hit = -1;
      for (int s = 0; s < runs_open; s++)
        if (hit < 0 && run_target[s] == tgt && run_key[s] == key) hit = s;
      if (hit < 0) begin
        if (runs_open >= NSLOT) flush_runs();
        hit = runs_open++;
        run_target[hit] = tgt;
        run_key[hit] = key;
        run_err[hit] = rec.err;
        run_cnt[hit] = 32'd0;
        run_work[hit] = {rec.wkc, rec.wkc};
        run_time[hit] = {rec.elapsed, rec.elapsed};
        run_nvals[hit] = 0;
        run_ovf[hit] = 1'b0;
        run_newest[hit] = '0;
      end
      if (run_cnt[hit] != 32'hFFFF_FFFF) run_cnt[hit]++;
      lo = run_work[hit][15:0];
      hi = run_work[hit][31:16];
      if (rec.wkc < lo) lo = rec.wkc;
      if (rec.wkc > hi) hi = rec.wkc;
      run_work[hit] = {hi, lo};
      tlo = run_time[hit][31:0];
      thi = run_time[hit][63:32];
      if (rec.elapsed < tlo) tlo = rec.elapsed;
      if (rec.elapsed > thi) thi = rec.elapsed;
      run_time[hit] = {thi, tlo};
      // Only successful reads carrying a value are recorded.
      if (st == 2'd0 && val != '0) begin
        run_newest[hit] = val;
        seen = 0;
        for (int k = 0; k < run_nvals[hit]; k++)
          if (run_vals[hit][k] == val) seen = 1;
        if (!seen) begin
          if (run_nvals[hit] < NVAL) run_vals[hit][run_nvals[hit]++] = val;
          else run_ovf[hit] = 1'b1;
        end
      end
    end
    if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
    foreach (batch_q[i]) expected_q.push_back(batch_q[i]);
  endtask

  // Sends one beat; a new burst may start after a random gap.
  task automatic send_beat(input logic [1:0] cmd, input record_t rec);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= rec;
    do @(posedge clk); while (!in_tready);
    predict_runs(cmd, rec);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_enable(input bit on);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    enabled = on;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic record_t make_rec(input logic [15:0] slave, input logic [15:0] obj,
                                       input logic [7:0] sub, input logic [1:0] outcome,
                                       input logic [31:0] ab, input logic [2:0] vsize,
                                       input logic [31:0] vbytes);
    record_t r;
    r = '0;
    r.slave = slave;
    r.obj = obj;
    r.sub = sub;
    r.outcome = outcome;
    r.abort_val = ab;
    r.vsize = vsize;
    r.vbytes = vbytes;
    r.wkc = 16'($urandom());
    r.err = 1'($urandom());
    r.elapsed = $urandom();
    return r;
  endfunction

  function automatic record_t noise_rec();
    record_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    r.pad = '0;
    return r;
  endfunction

  // Records and flushes while disabled: nothing comes out.
  task automatic test_disabled();
    send_beat(trc_pkg::CMD_READ, noise_rec());
    send_beat(trc_pkg::CMD_WRITE, noise_rec());
    send_beat(trc_pkg::CMD_NOP, noise_rec());
    send_beat(trc_pkg::CMD_FLUSH, noise_rec());
    wait_idle();
  endtask

  task automatic test_directed();
    record_t r;
    set_enable(1'b1);
    // Empty flush yields nothing.
    send_beat(trc_pkg::CMD_FLUSH, '0);
    // Extremes of the fields, then a hit that widens the bounds.
    r = make_rec(16'hFFFF, 16'hFFFF, 8'hFF, 2'd0, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF);
    r.wkc = 16'hFFFF;
    r.elapsed = 32'hFFFF_FFFF;
    send_beat(trc_pkg::CMD_READ, r);
    r.wkc = 16'h0;
    r.elapsed = 32'h0;
    r.vsize = 3'd7;
    send_beat(trc_pkg::CMD_READ, r);
    send_beat(trc_pkg::CMD_READ, make_rec(16'd0, 16'd0, 8'd0, 2'd0, 32'd0, 3'd0, 32'd0));
    // Bytes beyond the value size are dropped; a duplicate value is not stored.
    send_beat(trc_pkg::CMD_READ,
              make_rec(16'd1, 16'd2, 8'd3, 2'd0, 32'd0, 3'd1, 32'hABCD_EF12));
    send_beat(trc_pkg::CMD_READ,
              make_rec(16'd1, 16'd2, 8'd3, 2'd0, 32'd0, 3'd1, 32'h0000_0012));
    // Failed reads keep no value; outcome 3 behaves as timeout.
    send_beat(trc_pkg::CMD_READ,
              make_rec(16'd1, 16'd2, 8'd3, 2'd1, 32'h0604_0041, 3'd2, 32'h1234));
    send_beat(trc_pkg::CMD_READ, make_rec(16'd1, 16'd2, 8'd3, 2'd3, 32'd0, 3'd3, 32'h55));
    send_beat(trc_pkg::CMD_READ, make_rec(16'd1, 16'd2, 8'd3, 2'd2, 32'd0, 3'd3, 32'h66));
    send_beat(trc_pkg::CMD_FLUSH, '0);
    // Eight distinct values overflow a run.
    for (int k = 0; k < 8; k++)
      send_beat(trc_pkg::CMD_READ,
                make_rec(16'd5, 16'h6000, 8'd1, 2'd0, 32'd0, 3'd2, 32'(32'h100 + k)));
    // A write flushes and stands alone, with a value item even when failed.
    send_beat(trc_pkg::CMD_WRITE,
              make_rec(16'd7, 16'h7000, 8'd2, 2'd2, 32'h5, 3'd4, 32'hDEAD_BEEF));
    send_beat(trc_pkg::CMD_WRITE, make_rec(16'd7, 16'h7000, 8'd2, 2'd0, 32'd0, 3'd0, 32'd0));
    wait_idle();
  endtask

  // Nine distinct targets: the ninth finds the table full and flushes it.
  task automatic test_full_table();
    for (int k = 0; k < NSLOT + 1; k++)
      send_beat(trc_pkg::CMD_READ,
                make_rec(16'(k), 16'h1000, 8'd0, 2'd0, 32'd0, 3'd1, 32'(k)));
    send_beat(trc_pkg::CMD_NOP, noise_rec());
    send_beat(trc_pkg::CMD_FLUSH, '0);
    wait_idle();
  endtask

  // Runs over a small pool of targets and values so that hits are common.
  task automatic test_random(input int count);
    record_t r;
    int pick;
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        cmd = 2'($urandom_range(0, 3));
        r = noise_rec();
      end else begin
        r = make_rec(16'($urandom_range(0, 3)), 16'(32'h2000 + $urandom_range(0, 2)),
                     8'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ?
                     2'($urandom_range(1, 3)) : 2'd0, $urandom_range(0, 1),
                     3'($urandom_range(0, 5)), $urandom_range(0, 9) * 32'h0101_0101);
        if (pick < 88) cmd = trc_pkg::CMD_READ;
        else if (pick < 93) cmd = trc_pkg::CMD_WRITE;
        else cmd = trc_pkg::CMD_FLUSH;
      end
      send_beat(cmd, r);
    end
    send_beat(trc_pkg::CMD_FLUSH, '0);
    wait_idle();
  endtask

  initial begin
    enabled = 0;
    runs_open = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_full_table();
    test_random(120);
    // Drain the table before turning records off, then check they are ignored.
    send_beat(trc_pkg::CMD_FLUSH, '0);
    set_enable(1'b0);
    test_disabled();
    set_enable(1'b1);
    test_random(120);
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: stall phases are chosen at random between no stalling and light to heavy stalling.
  int stall_phase = 0;
  int stall_pct = 0;
  always @(posedge clk) begin
    result_t e;
    run_beat_t got;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        report("unexpected beat", out_tuser, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_tuser != e.kind) report("kind", out_tuser, e.kind);
        if (out_tlast != e.last) report("last", out_tlast, e.last);
        if (got.status != e.data.status) report("status", got.status, e.data.status);
        if (got.slave != e.data.slave) report("slave", got.slave, e.data.slave);
        if (got.object != e.data.object) report("object", got.object, e.data.object);
        if (got.abort_val != e.data.abort_val)
          report("abort", got.abort_val, e.data.abort_val);
        if (got.count != e.data.count) report("count", got.count, e.data.count);
        if (got.work != e.data.work) report("work", got.work, e.data.work);
        if (got.time_b != e.data.time_b) report("time", got.time_b, e.data.time_b);
        if (got.err != e.data.err) report("error flag", got.err, e.data.err);
        if (got.vsize != e.data.vsize) report("value size", got.vsize, e.data.vsize);
        if (got.value != e.data.value) report("value", got.value, e.data.value);
        if (got.pad != 1'b0) report("pad", got.pad, 0);
      end
    end
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 200);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
    end
    stall_phase--;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

>>> filelist.f
src/trc_pkg.sv
src/trc_cell.sv
src/transaction_run_coalescer.sv
tb/transaction_run_coalescer_test.sv
